### sv/cle_pkg.sv
// Shared types and constants for the cooked line editor.
// No dependencies; every other file of the block except cle_ram imports this package.
package cle_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned LIMIT_W  = 7;
  localparam int unsigned S_DATA_W = 16;

  localparam logic [CHAR_W-1:0] CH_EOF  = 8'h04;
  localparam logic [CHAR_W-1:0] CH_BS   = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NL   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_KILL = 8'h15;

  // Function codes carried in the input tuser.
  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Editing class of a typed character, as seen in cooked mode.
  typedef enum logic [1:0] {
    CLS_PLAIN,
    CLS_BS,
    CLS_KILL,
    CLS_EOL
  } cls_e;

  typedef struct packed {
    logic               is_read;
    cls_e               cls;
    logic [CHAR_W-1:0]  key_char;
    logic [LIMIT_W-1:0] limit;
  } cmd_t;

  typedef struct packed {
    logic reading;
  } back_status_t;

endpackage

### sv/cle_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/cle_front.sv
// Front end: accepts input words, decodes the function and character class
// and saturates the read limit. Depends on cle_pkg.
module cle_front import cle_pkg::*; #(
  parameter int unsigned MAX_READ = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic                s_tuser,
  output logic                cmd_valid_o,
  output cmd_t                cmd_o,
  input  logic                cmd_ready_i
);

  localparam logic [LIMIT_W-1:0] MaxLimit = LIMIT_W'(MAX_READ);

  logic               vld_q, vld_d;
  cmd_t               cmd_q, cmd_d;
  logic [CHAR_W-1:0]  key;
  logic [LIMIT_W-1:0] lim;
  logic               take;

  assign key      = s_tdata[CHAR_W-1:0];
  assign lim      = s_tdata[CHAR_W+LIMIT_W-1:CHAR_W];
  assign s_tready = !vld_q || cmd_ready_i;
  assign take     = s_tvalid && s_tready;

  always_comb begin
    cmd_d = cmd_q;
    vld_d = vld_q && !cmd_ready_i;
    if (take) begin
      vld_d          = 1'b1;
      cmd_d.is_read  = (s_tuser == FUNC_READ);
      cmd_d.key_char = key;
      cmd_d.limit    = (lim > MaxLimit) ? MaxLimit : lim;
      case (key)
        CH_BS:         cmd_d.cls = CLS_BS;
        CH_KILL:       cmd_d.cls = CLS_KILL;
        CH_NL, CH_EOF: cmd_d.cls = CLS_EOL;
        default:       cmd_d.cls = CLS_PLAIN;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

endmodule

### sv/cle_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
// Depends on cle_pkg.
module cle_cmd_fifo import cle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic ready_o,
  output logic valid_o,
  output cmd_t data_o,
  input  logic pop_i
);

  cmd_t       ent_q [2];
  logic       wp_q, wp_d;
  logic       rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = ent_q[rp_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wp_d  = do_push ? !wp_q : wp_q;
    rp_d  = do_pop ? !rp_q : rp_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wp_q] <= data_i;
    end
  end

endmodule

### sv/cle_back.sv
// Back end: owns the circular character store and its three indices, edits
// lines, serves reads and drives the output register. Depends on cle_pkg, cle_ram.
module cle_back import cle_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 2048
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAR_W-1:0] out_char_o,
  output logic [1:0]        out_user_o,   // [0] char_valid, [1] dropped
  output logic              out_last_o,
  output back_status_t      status_o
);

  localparam int unsigned IW = $clog2(STORE_DEPTH);
  localparam logic [IW-1:0] LastIdx = IW'(STORE_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_FLUSH
  } state_e;

  function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] i);
    return (i == LastIdx) ? '0 : i + IW'(1);
  endfunction

  function automatic logic [IW-1:0] dec_idx(input logic [IW-1:0] i);
    return (i == '0) ? LastIdx : i - IW'(1);
  endfunction

  state_e             state_q, state_d;
  logic [IW-1:0]      rd_q, rd_d, cm_q, cm_d, wr_q, wr_d;
  logic               raw_q, raw_d;
  logic [LIMIT_W-1:0] cnt_q, cnt_d, lim_q, lim_d;
  logic [LIMIT_W-1:0] cnt_inc;
  logic [CHAR_W-1:0]  pend_q, pend_d;
  logic               pend_vld_q, pend_vld_d;
  logic               ovld_q, ovld_d;
  logic [CHAR_W-1:0]  ochar_q, ochar_d;
  logic               ocv_q, ocv_d, olast_q, olast_d, odrop_q, odrop_d;

  logic              slot_free;
  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;
  logic [IW-1:0]     wr_nxt;
  logic              full;

  cle_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_q),
    .wdata_i (cmd_i.key_char),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign slot_free = !ovld_q || out_ready_i;
  assign wr_nxt    = inc_idx(wr_q);
  assign full      = (wr_nxt == rd_q);
  assign cnt_inc   = cnt_q + LIMIT_W'(1);

  always_comb begin
    state_d    = state_q;
    rd_d       = rd_q;
    cm_d       = cm_q;
    wr_d       = wr_q;
    raw_d      = raw_q;
    cnt_d      = cnt_q;
    lim_d      = lim_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    ovld_d     = ovld_q && !out_ready_i;
    ochar_d    = ochar_q;
    ocv_d      = ocv_q;
    olast_d    = olast_q;
    odrop_d    = odrop_q;
    cmd_pop_o  = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = rd_q;

    // Switching to raw mode commits whatever line is pending.
    if (cfg_valid_i) begin
      raw_d = cfg_data_i;
      if (cfg_data_i) begin
        cm_d = wr_q;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && slot_free) begin
          cmd_pop_o = 1'b1;
          if (!cmd_i.is_read) begin
            ovld_d  = 1'b1;
            ochar_d = '0;
            ocv_d   = 1'b0;
            olast_d = 1'b1;
            odrop_d = 1'b0;
            if (raw_q || cmd_i.cls == CLS_PLAIN || cmd_i.cls == CLS_EOL) begin
              if (full) begin
                odrop_d = 1'b1;
              end else begin
                ram_we = 1'b1;
                wr_d   = wr_nxt;
                if (raw_q || cmd_i.cls == CLS_EOL) begin
                  cm_d = wr_nxt;
                end
              end
            end else if (cmd_i.cls == CLS_BS) begin
              if (wr_q != cm_q) begin
                wr_d = dec_idx(wr_q);
              end
            end else begin
              wr_d = cm_q;
            end
          end else if (cmd_i.limit == '0 || rd_q == cm_q) begin
            ovld_d  = 1'b1;
            ochar_d = '0;
            ocv_d   = 1'b0;
            olast_d = 1'b1;
            odrop_d = 1'b0;
          end else begin
            ram_re     = 1'b1;
            rd_d       = inc_idx(rd_q);
            cnt_d      = '0;
            lim_d      = cmd_i.limit;
            pend_vld_d = 1'b0;
            state_d    = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        // A character is held back one fetch so that its last flag is known.
        if (slot_free) begin
          if (!raw_q && ram_rdata == CH_EOF) begin
            ovld_d  = 1'b1;
            ochar_d = pend_vld_q ? pend_q : '0;
            ocv_d   = pend_vld_q;
            olast_d = 1'b1;
            odrop_d = 1'b0;
            state_d = ST_IDLE;
          end else begin
            if (pend_vld_q) begin
              ovld_d  = 1'b1;
              ochar_d = pend_q;
              ocv_d   = 1'b1;
              olast_d = 1'b0;
              odrop_d = 1'b0;
            end
            pend_d     = ram_rdata;
            pend_vld_d = 1'b1;
            cnt_d      = cnt_inc;
            if (cnt_inc == lim_q || rd_q == cm_q) begin
              state_d = ST_FLUSH;
            end else begin
              ram_re = 1'b1;
              rd_d   = inc_idx(rd_q);
            end
          end
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          ovld_d  = 1'b1;
          ochar_d = pend_q;
          ocv_d   = 1'b1;
          olast_d = 1'b1;
          odrop_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_q       <= '0;
      cm_q       <= '0;
      wr_q       <= '0;
      raw_q      <= 1'b0;
      cnt_q      <= '0;
      lim_q      <= '0;
      pend_vld_q <= 1'b0;
      ovld_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_q       <= rd_d;
      cm_q       <= cm_d;
      wr_q       <= wr_d;
      raw_q      <= raw_d;
      cnt_q      <= cnt_d;
      lim_q      <= lim_d;
      pend_vld_q <= pend_vld_d;
      ovld_q     <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q  <= pend_d;
    ochar_q <= ochar_d;
    ocv_q   <= ocv_d;
    olast_q <= olast_d;
    odrop_q <= odrop_d;
  end

  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = ovld_q;
  assign out_char_o       = ochar_q;
  assign out_user_o       = {odrop_q, ocv_q};
  assign out_last_o       = olast_q;
  assign status_o.reading = (state_q != ST_IDLE);

endmodule

### sv/cooked_line_editor.sv
// Top level of the cooked line editor: front end, command queue, back end.
// Depends on cle_pkg, cle_front, cle_cmd_fifo, cle_back (and cle_ram below it).
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------
//  s_*      | in        | tuser func; tdata key_char, read_limit
//  m_*      | out       | tdata out_char; tuser char_valid, dropped; tlast
//  cfg_*    | in        | raw_mode
//
// A read streams its characters through the store's registered read port and ends
// with a flush, unless it meets an end-of-file mark in cooked mode; a read with a zero
// limit or nothing committed returns a single empty result. The front register and the
// queue sit ahead of the back end. Reset clears the indices and mode at once; the store
// needs no clearing pass.
// Either side may stall freely; the queue decouples them.
module cooked_line_editor import cle_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 2048,
  parameter int unsigned MAX_READ    = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] key_char, [14:8] read_limit
  input  logic                s_tuser,   // [0] func
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [CHAR_W-1:0]   m_tdata,   // [7:0] out_char
  output logic [1:0]          m_tuser,   // [0] char_valid, [1] dropped
  output logic                m_tlast,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);

  logic         f_valid, q_ready, q_valid, q_pop;
  cmd_t         f_cmd, q_cmd;
  back_status_t bst;

  cle_front #(
    .MAX_READ (MAX_READ)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .cmd_valid_o (f_valid),
    .cmd_o       (f_cmd),
    .cmd_ready_i (q_ready)
  );

  cle_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (f_cmd),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (q_cmd),
    .pop_i   (q_pop)
  );

  cle_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .out_char_o  (m_tdata),
    .out_user_o  (m_tuser),
    .out_last_o  (m_tlast),
    .status_o    (bst)
  );

`ifndef ASSERT_OFF
  // The back end only pops a command that the queue actually holds.
  a_pop_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("command popped from an empty queue");

  // A freshly loaded returned character comes from a read in progress.
  a_char_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser[0] && !$past(m_tvalid) |-> $past(bst.reading))
    else $error("character result outside a read");

  // Results without a character are always the final one of their item.
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == '0)
    else $error("empty result not marked last");
`endif

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for cooked_line_editor: directed script, random line traffic
// and a long output hold-off, all checked against an in-bench predictor.
// Depends on cle_pkg and the cooked_line_editor RTL only.
module testbench;
  import cle_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HALF_PERIOD  = 4;
  localparam int unsigned STORE_DEPTH  = 2048;
  localparam int unsigned IDX_W        = $clog2(STORE_DEPTH);
  localparam int unsigned MAX_READ     = 64;
  localparam int unsigned RANDOM_ITEMS = 200;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              char_valid;
    logic              last;
    logic              dropped;
  } word_t;

  // A key acknowledgement and an empty read look the same on the output.
  localparam word_t BARE_WORD = {8'h00, 1'b0, 1'b1, 1'b0};

  typedef enum logic [1:0] {
    ROW_KEY,
    ROW_READ,
    ROW_MODE
  } row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [CHAR_W-1:0] value;
    logic              typed;
    word_t             want;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                s_tuser = FUNC_KEY;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [CHAR_W-1:0]   m_tdata;
  logic [1:0]          m_tuser;
  logic                m_tlast;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_data_i = 1'b0;

  // Shadow of the line discipline.
  logic [CHAR_W-1:0] shadow_store [STORE_DEPTH];
  logic [IDX_W-1:0]  rd_ptr = '0;
  logic [IDX_W-1:0]  commit_ptr = '0;
  logic [IDX_W-1:0]  wr_ptr = '0;
  logic              raw_on = 1'b0;

  word_t fresh[$];
  word_t awaited[$];
  row_t  script[$];
  int    fails = 0;
  int    sent = 0;
  bit    src_idle = 1'b0;
  bit    sink_idle = 1'b0;
  bit    hold_req = 1'b0;

  cooked_line_editor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  function automatic word_t make_word(logic [CHAR_W-1:0] ch, logic v, logic l, logic d);
    word_t w;
    w.out_char   = ch;
    w.char_valid = v;
    w.last       = l;
    w.dropped    = d;
    return w;
  endfunction

  // Edits the pending line or drains committed characters; the words caused land in fresh.
  function automatic void edit_or_read(logic func, logic [CHAR_W-1:0] ch,
                                       logic [LIMIT_W-1:0] lim);
    logic [IDX_W-1:0]  nxt;
    logic [CHAR_W-1:0] c;
    logic              drop;
    int unsigned       cap;
    int unsigned       n;
    fresh.delete();
    if (func == FUNC_KEY) begin
      drop = 1'b0;
      if (raw_on || (ch != CH_BS && ch != CH_KILL)) begin
        nxt = wr_ptr + IDX_W'(1);
        if (nxt == rd_ptr) begin
          drop = 1'b1;
        end else begin
          shadow_store[wr_ptr] = ch;
          wr_ptr = nxt;
        end
        if (raw_on || (!drop && (ch == CH_NL || ch == CH_EOF))) commit_ptr = wr_ptr;
      end else if (ch == CH_BS) begin
        if (wr_ptr != commit_ptr) wr_ptr = wr_ptr - IDX_W'(1);
      end else begin
        wr_ptr = commit_ptr;
      end
      fresh.push_back(make_word(8'h00, 1'b0, 1'b1, drop));
    end else begin
      cap = (lim > MAX_READ) ? MAX_READ : lim;
      n = 0;
      while (n < cap && rd_ptr != commit_ptr) begin
        c = shadow_store[rd_ptr];
        rd_ptr = rd_ptr + IDX_W'(1);
        if (!raw_on && c == CH_EOF) break;
        fresh.push_back(make_word(c, 1'b1, 1'b0, 1'b0));
        n++;
      end
      if (n == 0) fresh.push_back(BARE_WORD);
      else fresh[fresh.size()-1].last = 1'b1;
    end
  endfunction

  // Called just after a rising edge; returns just after the edge that took the word.
  task automatic offer_word(logic func, logic [CHAR_W-1:0] ch, logic [LIMIT_W-1:0] lim,
                            logic typed, word_t want);
    int gap;
    gap = src_idle ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, lim, ch};
    s_tuser  <= func;
    do @(posedge clk_i); while (!s_tready);
    sent++;
    edit_or_read(func, ch, lim);
    if (typed) awaited.push_back(want);
    else foreach (fresh[i]) awaited.push_back(fresh[i]);
  endtask

  // Mode changes only once the block has drained and settled.
  task automatic set_raw_mode(logic v);
    s_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    raw_on = v;
    if (v) commit_ptr = wr_ptr;
  endtask

  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return CH_BS;
    if (r < 13) return CH_KILL;
    if (r < 25) return CHAR_W'($urandom_range(0, 255));
    return CHAR_W'($urandom_range(8'h20, 8'h7E));
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 10) return LIMIT_W'($urandom_range(MAX_READ + 1, 127));
    if (r < 40) return LIMIT_W'($urandom_range(1, 4));
    return LIMIT_W'($urandom_range(1, MAX_READ));
  endfunction

  function automatic void add_row(row_kind_e kind, logic [CHAR_W-1:0] value, logic typed);
    row_t r;
    r.kind  = kind;
    r.value = value;
    r.typed = typed;
    r.want  = BARE_WORD;
    script.push_back(r);
  endfunction

  initial begin : sink
    word_t got;
    word_t exp;
    int    stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = sink_idle ? $urandom_range(0, 16) : 0;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      got = make_word(m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
      if (awaited.size() == 0) begin
        fails++;
        $display("%0t: word with nothing expected: actual char=%h valid=%b last=%b dropped=%b",
                 $time, got.out_char, got.char_valid, got.last, got.dropped);
      end else begin
        exp = awaited.pop_front();
        if (got.out_char !== exp.out_char || got.char_valid !== exp.char_valid ||
            got.last !== exp.last || got.dropped !== exp.dropped) begin
          fails++;
          $display("%0t: mismatch: expected char=%h valid=%b last=%b dropped=%b, %s",
                   $time, exp.out_char, exp.char_valid, exp.last, exp.dropped,
                   $sformatf("actual char=%h valid=%b last=%b dropped=%b",
                             got.out_char, got.char_valid, got.last, got.dropped));
        end
      end
    end
  end

  initial begin : stimulus
    int   phase;
    int   kind;
    int   len;
    row_t r;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed script: cooked editing, end-of-file handling, limits, then raw mode.
    add_row(ROW_MODE, 8'h00, 1'b0);
    add_row(ROW_READ, 8'd1, 1'b1);       // nothing committed yet
    add_row(ROW_KEY, 8'h61, 1'b1);
    add_row(ROW_KEY, CH_BS, 1'b1);
    add_row(ROW_KEY, CH_BS, 1'b1);       // backspace on an empty line is ignored
    add_row(ROW_KEY, 8'hFF, 1'b1);
    add_row(ROW_KEY, 8'h00, 1'b1);
    add_row(ROW_KEY, CH_KILL, 1'b1);
    add_row(ROW_KEY, 8'h68, 1'b1);
    add_row(ROW_KEY, 8'h69, 1'b1);
    add_row(ROW_KEY, CH_NL, 1'b1);
    add_row(ROW_READ, 8'd0, 1'b1);       // zero limit consumes nothing
    add_row(ROW_READ, 8'd2, 1'b0);
    add_row(ROW_READ, 8'd127, 1'b0);     // saturates to the maximum read
    add_row(ROW_KEY, 8'h78, 1'b1);
    add_row(ROW_KEY, CH_EOF, 1'b1);
    add_row(ROW_KEY, 8'h79, 1'b1);
    add_row(ROW_KEY, CH_EOF, 1'b1);
    add_row(ROW_READ, 8'd64, 1'b0);
    add_row(ROW_READ, 8'd1, 1'b0);       // the end-of-file mark stays behind the limit
    add_row(ROW_READ, 8'd1, 1'b1);       // leading end-of-file is eaten, nothing returned
    add_row(ROW_KEY, 8'h70, 1'b1);
    add_row(ROW_MODE, 8'h01, 1'b0);      // switching to raw commits the pending line
    add_row(ROW_KEY, CH_EOF, 1'b1);
    add_row(ROW_KEY, CH_KILL, 1'b1);
    add_row(ROW_KEY, CH_BS, 1'b1);
    add_row(ROW_READ, 8'd64, 1'b0);

    foreach (script[i]) begin
      r = script[i];
      case (r.kind)
        ROW_MODE: set_raw_mode(r.value[0]);
        ROW_KEY:  offer_word(FUNC_KEY, r.value, '0, r.typed, r.want);
        default:  offer_word(FUNC_READ, 8'h00, r.value[LIMIT_W-1:0], r.typed, r.want);
      endcase
    end

    // Random traffic: mostly whole lines followed by reads, with some noise.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      set_raw_mode(phase[0]);
      src_idle  = $urandom_range(0, 3) != 0;
      sink_idle = $urandom_range(0, 3) != 0;
      if (phase == 3) begin
        // Long output hold-off while input keeps coming, so the block backs up.
        hold_req = 1'b1;
        src_idle = 1'b0;
      end
      repeat ($urandom_range(2, 5)) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          len = $urandom_range(0, 14);
          repeat (len) offer_word(FUNC_KEY, pick_char(), '0, 1'b0, BARE_WORD);
          offer_word(FUNC_KEY, (kind < 5) ? CH_NL : CH_EOF, '0, 1'b0, BARE_WORD);
          offer_word(FUNC_READ, 8'h00, pick_limit(), 1'b0, BARE_WORD);
          if (kind == 0) offer_word(FUNC_READ, 8'h00, pick_limit(), 1'b0, BARE_WORD);
        end else if (kind < 9) begin
          offer_word(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                     LIMIT_W'($urandom_range(0, 127)), 1'b0, BARE_WORD);
        end else begin
          len = $urandom_range(1, 8);
          repeat (len) offer_word(FUNC_KEY, pick_char(), '0, 1'b0, BARE_WORD);
          offer_word(FUNC_READ, 8'h00, pick_limit(), 1'b0, BARE_WORD);
        end
      end
      phase++;
    end

    set_raw_mode(1'b1);
    sink_idle = 1'b0;
    repeat (4) offer_word(FUNC_KEY, CHAR_W'($urandom_range(0, 255)), '0, 1'b0, BARE_WORD);
    offer_word(FUNC_READ, 8'h00, 7'd127, 1'b0, BARE_WORD);

    s_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #(2 * HALF_PERIOD * 1_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
